// ===== hdl/ega_pkg.sv =====
package ega_pkg;

  localparam int EST_W = 16;
  localparam int CNT_W = 16;
  localparam int THR_W = 17;
  localparam int GAIN_W = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_INDEX_W = 1;
  localparam int IN_ARM_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXPLORE_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STEP_GAIN = 1'd1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 17'd26214;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd13107;

  localparam logic OP_CHOOSE = 1'b0;
  localparam logic OP_REWARD = 1'b1;

  typedef struct packed {
    logic operation;
    logic [15:0] explore_draw;
    logic [IN_ARM_W-1:0] random_arm;
    logic [IN_ARM_W-1:0] arm;
    logic signed [EST_W-1:0] reward;
  } in_item_t;

  typedef struct packed {
    logic [IN_ARM_W-1:0] chosen_arm;
    logic explored;
    logic signed [EST_W-1:0] estimate;
    logic [CNT_W-1:0] pull_count;
  } out_item_t;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic [CNT_W-1:0] pull_count;
  } arm_entry_t;

endpackage

// ===== hdl/ega_stream_if.sv =====
interface ega_stream_if #(
  parameter type payload_t = logic
) ();
  logic valid;
  logic ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ega_ram.sv =====
module ega_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/epsilon_greedy_bandit_agent.sv =====
// Epsilon-greedy bandit agent. Each arm's Q8.8 estimate and saturating pull
// count sit in one entry of a small state memory with a single read port and a
// registered read. A greedy choose beat reads every entry in turn, one per
// cycle, before its result is loaded; an exploring choose beat goes through
// read, then the result register, and a reward beat through read, multiply
// by the gain, round and saturate with write-back, then the result register.
// One beat is in work at a time; the next is accepted in the cycle after the
// result is loaded, even if that result has not yet been taken. A stalled
// result holds the next result back in its final cycle. After reset every
// entry reads as zero until its arm is first rewarded.
module epsilon_greedy_bandit_agent
  import ega_pkg::*;
#(
  parameter int ARMS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ega_stream_if.sink             req,
  ega_stream_if.source           rsp
);

  localparam int AW = $clog2(ARMS);
  localparam int IW = 8;
  localparam logic [IW-1:0] ARMS_W = IW'(ARMS);
  localparam logic [AW-1:0] LAST_ARM = AW'(ARMS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [THR_W-1:0] explore_threshold;
  logic [GAIN_W-1:0] step_gain;

  logic op;
  logic explored;
  logic [AW-1:0] sel;
  logic [AW-1:0] rd_idx;
  logic signed [EST_W-1:0] reward;
  logic signed [EST_W-1:0] cur_est;
  logic [CNT_W-1:0] cur_cnt;
  logic signed [32:0] prod;
  logic [ARMS-1:0] written;
  logic rd_valid;
  logic rsp_valid;
  out_item_t rsp_data;

  logic [AW-1:0] raddr;
  logic [$bits(arm_entry_t)-1:0] rdata;
  arm_entry_t entry;
  arm_entry_t wentry;
  logic we;

  logic accept;
  logic explore_now;
  logic [IW-1:0] rarm_ext;
  logic [IW-1:0] warm_ext;
  logic [AW-1:0] rarm_idx;
  logic [AW-1:0] warm_idx;
  logic signed [16:0] diff;
  logic signed [16:0] gain_s;
  logic signed [33:0] rounded;
  logic signed [17:0] delta;
  logic signed [18:0] sum;
  logic signed [EST_W-1:0] new_est;
  logic [CNT_W-1:0] new_cnt;
  logic load_out;

  assign req.ready = (state == S_IDLE);
  assign accept = req.valid && req.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data = rsp_data;

  assign rarm_ext = IW'(req.data.random_arm);
  assign warm_ext = IW'(req.data.arm);
  assign rarm_idx = AW'((rarm_ext >= ARMS_W) ? rarm_ext - ARMS_W : rarm_ext);
  assign warm_idx = AW'((warm_ext >= ARMS_W) ? warm_ext - ARMS_W : warm_ext);
  assign explore_now = (req.data.operation == OP_CHOOSE) &&
                       ({1'b0, req.data.explore_draw} < explore_threshold);

  always_comb begin
    if (state == S_SCAN) begin
      raddr = rd_idx + AW'(1);
    end else if (req.data.operation == OP_REWARD) begin
      raddr = warm_idx;
    end else if (explore_now) begin
      raddr = rarm_idx;
    end else begin
      raddr = '0;
    end
  end

  assign entry = rd_valid ? arm_entry_t'(rdata) : '0;

  assign diff = {reward[EST_W-1], reward} - {cur_est[EST_W-1], cur_est};
  assign gain_s = $signed({1'b0, step_gain});
  assign rounded = {prod[32], prod} + 34'sd32768;
  assign delta = rounded[33:16];
  assign sum = {{3{cur_est[EST_W-1]}}, cur_est} + {delta[17], delta};

  always_comb begin
    if (sum > 19'sd32767) begin
      new_est = 16'sh7FFF;
    end else if (sum < -19'sd32768) begin
      new_est = 16'sh8000;
    end else begin
      new_est = sum[EST_W-1:0];
    end
  end

  assign new_cnt = (cur_cnt == {CNT_W{1'b1}}) ? cur_cnt : cur_cnt + CNT_W'(1);
  assign we = (state == S_ADD);
  assign wentry = '{estimate: new_est, pull_count: new_cnt};
  assign load_out = (state == S_FIN) && (!rsp_valid || rsp.ready);

  ega_ram #(
    .WIDTH($bits(arm_entry_t)),
    .DEPTH(ARMS)
  ) u_ram (
    .clk(clk),
    .we(we),
    .waddr(sel),
    .wdata(wentry),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      explore_threshold <= THRESHOLD_RESET;
      step_gain <= GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPLORE_THRESHOLD: explore_threshold <= cfg_data[THR_W-1:0];
        CFG_STEP_GAIN: step_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      written <= '0;
      rd_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rd_valid <= written[raddr];
      if (we) begin
        written[sel] <= 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.data.operation == OP_CHOOSE && !explore_now) begin
              state <= S_SCAN;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= (op == OP_REWARD) ? S_MUL : S_FIN;
        end
        S_SCAN: begin
          if (rd_idx == LAST_ARM) begin
            state <= S_FIN;
          end
        end
        S_MUL: state <= S_ADD;
        S_ADD: state <= S_FIN;
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= req.data.operation;
      explored <= explore_now;
      reward <= req.data.reward;
      sel <= (req.data.operation == OP_REWARD) ? warm_idx : rarm_idx;
      rd_idx <= '0;
    end
    if (state == S_READ) begin
      cur_est <= entry.estimate;
      cur_cnt <= entry.pull_count;
    end
    if (state == S_SCAN) begin
      rd_idx <= rd_idx + AW'(1);
      if (rd_idx == '0 || entry.estimate > cur_est) begin
        cur_est <= entry.estimate;
        cur_cnt <= entry.pull_count;
        sel <= rd_idx;
      end
    end
    if (state == S_MUL) begin
      prod <= diff * gain_s;
    end
    if (state == S_ADD) begin
      cur_est <= new_est;
      cur_cnt <= new_cnt;
    end
    if (load_out) begin
      rsp_data.chosen_arm <= IN_ARM_W'(sel);
      rsp_data.explored <= explored;
      rsp_data.estimate <= cur_est;
      rsp_data.pull_count <= cur_cnt;
    end
  end

endmodule

// ===== hdl/ega_checker.sv =====
module ega_checker
  import ega_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input out_item_t rsp_data
);

  // A result waits unchanged until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result beat changed while stalled");

  // Work on one beat at a time: the agent is busy right after an acceptance.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("beat accepted while the previous one is still in work");

  // No result can appear in the cycle after reset.
  assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result presented straight after reset");

endmodule

bind epsilon_greedy_bandit_agent ega_checker u_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data(rsp.data)
);
